@@ src/cesd_pkg.sv @@
// cesd_pkg: shared types and constants for the escape sequence decoder
// no dependencies; used by the step logic, the top level and the checker
package cesd_pkg;

   localparam logic [1:0] MODE_BODY  = 2'd0;
   localparam logic [1:0] MODE_CARET = 2'd1;
   localparam logic [1:0] MODE_OCTAL = 2'd2;

   localparam logic [1:0] KIND_VALUE = 2'd0;
   localparam logic [1:0] KIND_CONT  = 2'd1;
   localparam logic [1:0] KIND_TERM  = 2'd2;

   localparam logic [1:0] LEVELS_MAX = 2'd2;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_NL    = 8'h0a;
   localparam logic [7:0] CH_BSL   = 8'h5c;
   localparam logic [7:0] CH_CARET = 8'h5e;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6e;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_V     = 8'h76;

   localparam logic [8:0] VAL_BEL        = 9'o007;
   localparam logic [8:0] VAL_BS         = 9'o010;
   localparam logic [8:0] VAL_ESC        = 9'o033;
   localparam logic [8:0] VAL_FF         = 9'o014;
   localparam logic [8:0] VAL_NL         = 9'o012;
   localparam logic [8:0] VAL_CR         = 9'o015;
   localparam logic [8:0] VAL_TAB        = 9'o011;
   localparam logic [8:0] VAL_VT         = 9'o013;
   localparam logic [8:0] VAL_QMARK      = 9'o077;
   localparam logic [8:0] VAL_DEL        = 9'o177;
   localparam logic [8:0] VAL_CONT_CARET = 9'o236;

   typedef struct packed {
      logic [1:0] mode;
      logic [1:0] levels;
      logic [8:0] accum;
      logic [1:0] digits;
   } state_type;

   localparam state_type STATE_RESET = '{
      mode:   MODE_BODY,
      levels: 2'd0,
      accum:  9'd0,
      digits: 2'd0
   };

   typedef struct packed {
      logic [8:0] decoded_value;
      logic [1:0] result_kind;
      logic       byte_consumed;
   } result_type;

endpackage

@@ src/cesd_req_if.sv @@
// cesd_req_if: valid/ready channel carrying one escape body byte per transfer
// no dependencies
interface cesd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink (input valid, input char_in, output ready);
endinterface

@@ src/cesd_rsp_if.sv @@
// cesd_rsp_if: valid/ready channel carrying one decoded escape per transfer
// no dependencies
interface cesd_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] decoded_value;
   logic [1:0] result_kind;
   logic       byte_consumed;

   modport source (output valid, output decoded_value, output result_kind,
                   output byte_consumed, input ready);
   modport sink (input valid, input decoded_value, input result_kind,
                 input byte_consumed, output ready);
endinterface

@@ src/cesd_step.sv @@
// cesd_step: combinational decode of one byte against the current parse state
// depends on cesd_pkg
module cesd_step #(
   parameter int MAX_OCTAL_DIGITS = 3
) (
   input  cesd_pkg::state_type  state,
   input  logic [7:0]           char_in,
   output cesd_pkg::state_type  next_state,
   output logic                 emit,
   output cesd_pkg::result_type result
);
   import cesd_pkg::*;

   localparam logic [1:0] MaxDigits = 2'(MAX_OCTAL_DIGITS);

   function automatic logic [8:0] mask_once(input logic [8:0] v);
      logic [8:0] m;
      if (v == VAL_QMARK) begin
         m = VAL_DEL;
      end else begin
         m = {1'b0, v[7], 2'b00, v[4:0]};
      end
      return m;
   endfunction

   function automatic logic [8:0] apply_carets(input logic [8:0] v, input logic [1:0] lv);
      logic [8:0] m;
      case (lv)
         2'd0: m = v;
         2'd1: m = mask_once(v);
         default: m = mask_once(mask_once(v));
      endcase
      return m;
   endfunction

   logic       is_octal;
   logic [8:0] digit;
   logic [8:0] char_wide;
   logic [8:0] accum_next;
   logic [1:0] digits_next;
   state_type  work;

   assign is_octal    = char_in inside {[8'h30:8'h37]};
   assign digit       = {6'd0, char_in[2:0]};
   assign char_wide   = {1'b0, char_in};
   assign accum_next  = {state.accum[5:0], char_in[2:0]};
   assign digits_next = state.digits + 2'd1;

   always_comb begin
      work = state;
      emit = 1'b0;
      result.decoded_value = 9'd0;
      result.result_kind   = KIND_VALUE;
      result.byte_consumed = 1'b1;

      if (state.mode == MODE_OCTAL) begin
         if (!is_octal) begin
            emit = 1'b1;
            result.decoded_value = apply_carets(state.accum, state.levels);
            result.byte_consumed = 1'b0;
         end else if (digits_next >= MaxDigits) begin
            emit = 1'b1;
            result.decoded_value = apply_carets(accum_next, state.levels);
         end else begin
            work.accum  = accum_next;
            work.digits = digits_next;
         end
      end else if (char_in == CH_NUL) begin
         emit = 1'b1;
         result.result_kind   = KIND_TERM;
         result.byte_consumed = 1'b0;
      end else if (state.mode == MODE_CARET) begin
         if (char_in == CH_BSL) begin
            work.mode = MODE_BODY;
         end else begin
            emit = 1'b1;
            result.decoded_value = apply_carets(char_wide, state.levels);
         end
      end else begin
         case (char_in)
            CH_A: begin
               emit = 1'b1;
               result.decoded_value = apply_carets(VAL_BEL, state.levels);
            end
            CH_B: begin
               emit = 1'b1;
               result.decoded_value = apply_carets(VAL_BS, state.levels);
            end
            CH_E: begin
               emit = 1'b1;
               result.decoded_value = apply_carets(VAL_ESC, state.levels);
            end
            CH_F: begin
               emit = 1'b1;
               result.decoded_value = apply_carets(VAL_FF, state.levels);
            end
            CH_N: begin
               emit = 1'b1;
               result.decoded_value = apply_carets(VAL_NL, state.levels);
            end
            CH_R: begin
               emit = 1'b1;
               result.decoded_value = apply_carets(VAL_CR, state.levels);
            end
            CH_T: begin
               emit = 1'b1;
               result.decoded_value = apply_carets(VAL_TAB, state.levels);
            end
            CH_V: begin
               emit = 1'b1;
               result.decoded_value = apply_carets(VAL_VT, state.levels);
            end
            CH_NL: begin
               emit = 1'b1;
               if (state.levels == 2'd0) begin
                  result.result_kind = KIND_CONT;
               end else begin
                  result.decoded_value = VAL_CONT_CARET;
               end
            end
            CH_CARET: begin
               if (state.levels < LEVELS_MAX) begin
                  work.levels = state.levels + 2'd1;
               end
               work.mode = MODE_CARET;
            end
            default: begin
               if (is_octal) begin
                  if (MaxDigits <= 2'd1) begin
                     emit = 1'b1;
                     result.decoded_value = apply_carets(digit, state.levels);
                  end else begin
                     work.mode   = MODE_OCTAL;
                     work.accum  = digit;
                     work.digits = 2'd1;
                  end
               end else begin
                  emit = 1'b1;
                  result.decoded_value = apply_carets(char_wide, state.levels);
               end
            end
         endcase
      end

      next_state = emit ? STATE_RESET : work;
   end

endmodule

@@ src/c_escape_sequence_decoder_unit.sv @@
// c_escape_sequence_decoder_unit: one byte per cycle while ready is high, result
// registered on the transfer of the byte that completes the escape
// a two-entry output buffer (output register plus skid) lets input continue
// while a result waits; ready depends only on the skid register
// reset (synchronous) returns the parse state to the start of an escape and
// empties the output buffer
module c_escape_sequence_decoder_unit #(
   parameter int MAX_OCTAL_DIGITS = 3
) (
   input logic          clock,
   input logic          reset,
   cesd_req_if.sink     req_bus,
   cesd_rsp_if.source   rsp_bus
);
   import cesd_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   logic       emit;
   result_type result;

   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_data_ff;
   result_type out_data_in;
   logic       skid_valid_ff;
   logic       skid_valid_in;
   result_type skid_data_ff;
   result_type skid_data_in;

   logic       accept;
   logic       take;

   cesd_step #(
      .MAX_OCTAL_DIGITS(MAX_OCTAL_DIGITS)
   ) u_step (
      .state      (state_ff),
      .char_in    (req_bus.char_in),
      .next_state (state_in),
      .emit       (emit),
      .result     (result)
   );

   assign req_bus.ready = !skid_valid_ff;
   assign accept        = req_bus.valid && req_bus.ready;
   assign take          = out_valid_ff && rsp_bus.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (take) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (accept && emit) begin
         if (!out_valid_in) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= STATE_RESET;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.decoded_value = out_data_ff.decoded_value;
   assign rsp_bus.result_kind   = out_data_ff.result_kind;
   assign rsp_bus.byte_consumed = out_data_ff.byte_consumed;

endmodule

@@ src/cesd_checker.sv @@
// cesd_checker: port-level assertions for the escape sequence decoder
// depends on cesd_pkg; bound to c_escape_sequence_decoder_unit below
module cesd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [8:0] rsp_decoded_value,
   input logic [1:0] rsp_result_kind,
   input logic       rsp_byte_consumed
);
   import cesd_pkg::*;

   // output buffer empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stalled transfer keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      ($past(rsp_valid && !rsp_ready) && $past(!reset)) |->
         (rsp_valid && $stable(rsp_decoded_value) && $stable(rsp_result_kind)
          && $stable(rsp_byte_consumed)))
      else $error("stalled result changed");

   // input only stalls when both buffer entries are full
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with empty output");

   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_result_kind == KIND_VALUE || rsp_result_kind == KIND_CONT
                     || rsp_result_kind == KIND_TERM))
      else $error("unused result kind");

   // terminator is pushed back with a zero value
   a_term: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == KIND_TERM && req_valid) |->
         (!rsp_byte_consumed && rsp_decoded_value == 9'd0))
      else $error("bad terminator result");

endmodule

bind c_escape_sequence_decoder_unit cesd_checker u_cesd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_decoded_value (rsp_bus.decoded_value),
   .rsp_result_kind   (rsp_bus.result_kind),
   .rsp_byte_consumed (rsp_bus.byte_consumed)
);
